/* src/gnps_pkg.sv */
// ----------------------------------------------------------------------------
// gnps_pkg: shared types and constants of the gated nearest point search
// Holds the payload structs, operation and status codes, the controller
// state type and the command and status bundles between the two halves.
// ----------------------------------------------------------------------------
package gnps_pkg;

    // Coordinate width is fixed by the payload fields (signed Q4.12).
    localparam int COORD_BITS          = 16;
    localparam int INDEX_W             = 10;
    localparam int DIST_W              = 34;
    localparam int STATUS_W            = 2;
    localparam int OP_W                = 2;
    localparam int STORE_DEPTH_DEFAULT = 1024;

    localparam logic [DIST_W-1:0] GATE_RESET = 34'd2055208;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]              operation;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] nearest_x;
        logic signed [COORD_BITS-1:0] nearest_y;
        logic signed [COORD_BITS-1:0] nearest_z;
        logic [INDEX_W-1:0]           nearest_index;
        logic [DIST_W-1:0]            dist_sq;
        logic                         within_gate;
        logic [STATUS_W-1:0]          status;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } t_point;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic accept;     // take the input transaction now
        logic scan_read;  // read the next stored point into the pipeline
        logic out_load;   // load the pending result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic scan_last;  // current scan address is the last stored point
        logic pipe_busy;  // a distance is still in flight
        logic out_free;   // output register can take a result this cycle
    } t_dp_status;

endpackage

/* src/gnps_ctrl.sv */
// ----------------------------------------------------------------------------
// gnps_ctrl: controller of the gated nearest point search
// Sequences accept, store scan, pipeline drain and result hand-off.
// ----------------------------------------------------------------------------
module gnps_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic [gnps_pkg::OP_W-1:0] i_op,
    input  gnps_pkg::t_dp_status    i_status,
    output gnps_pkg::t_dp_cmd       o_cmd,
    output logic                    o_in_stall
);

    gnps_pkg::t_state r_state;
    gnps_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gnps_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            gnps_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == gnps_pkg::OP_APPEND) begin
                        n_state = gnps_pkg::ST_RESULT;
                    end else if (i_op == gnps_pkg::OP_QUERY) begin
                        n_state = i_status.count_zero ? gnps_pkg::ST_RESULT
                                                      : gnps_pkg::ST_SCAN;
                    end
                end
            end
            gnps_pkg::ST_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = gnps_pkg::ST_DRAIN;
                end
            end
            gnps_pkg::ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = gnps_pkg::ST_RESULT;
                end
            end
            gnps_pkg::ST_RESULT: begin
                if (i_status.out_free) begin
                    n_state = gnps_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gnps_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            gnps_pkg::ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            gnps_pkg::ST_SCAN: begin
                o_cmd.scan_read = 1'b1;
            end
            gnps_pkg::ST_DRAIN: begin
                o_cmd = '0;
            end
            gnps_pkg::ST_RESULT: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* src/gnps_datapath.sv */
// ----------------------------------------------------------------------------
// gnps_datapath: point store, distance pipeline and result register
// Holds the point memory and count, the gate register, a four stage
// distance pipeline with the running minimum, and the output register.
// ----------------------------------------------------------------------------
module gnps_datapath #(
    parameter int STORE_DEPTH = gnps_pkg::STORE_DEPTH_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gnps_pkg::t_dp_cmd           i_cmd,
    output gnps_pkg::t_dp_status        o_status,
    input  gnps_pkg::t_in_item          i_in_data,
    input  logic                        i_cfg_wr,
    input  logic [gnps_pkg::DIST_W-1:0] i_cfg_data,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output gnps_pkg::t_out_item         o_out_data
);

    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int CW     = gnps_pkg::COORD_BITS;
    localparam int DW     = gnps_pkg::DIST_W;

    gnps_pkg::t_point mem [STORE_DEPTH];

    logic [CNT_W-1:0]        r_count;
    logic [DW-1:0]           r_gate;
    gnps_pkg::t_point        r_query;
    logic [ADDR_W-1:0]       r_scan_idx;

    logic                    r_pend_query;
    logic [gnps_pkg::STATUS_W-1:0] r_pend_status;
    logic [ADDR_W-1:0]       r_pend_idx;

    // Stage 1: memory read data.
    logic                    r_s1_valid;
    logic [ADDR_W-1:0]       r_s1_idx;
    gnps_pkg::t_point        r_s1_pt;
    // Stage 2: per-axis squares.
    logic                    r_s2_valid;
    logic [ADDR_W-1:0]       r_s2_idx;
    gnps_pkg::t_point        r_s2_pt;
    logic [DW-1:0]           r_sq_x, r_sq_y, r_sq_z;
    // Stage 3: summed distance.
    logic                    r_s3_valid;
    logic [ADDR_W-1:0]       r_s3_idx;
    gnps_pkg::t_point        r_s3_pt;
    logic [DW-1:0]           r_s3_dist;
    // Running minimum.
    logic                    r_best_valid;
    logic [ADDR_W-1:0]       r_best_idx;
    gnps_pkg::t_point        r_best_pt;
    logic [DW-1:0]           r_best_dist;

    logic                    r_out_valid;
    gnps_pkg::t_out_item     r_out;
    gnps_pkg::t_out_item     n_out;

    logic                    count_full;
    logic                    is_append;
    logic                    is_query;
    logic                    is_clear;
    logic signed [CW:0]      d_x, d_y, d_z;
    logic signed [2*CW+1:0]  p_x, p_y, p_z;

    assign count_full = (r_count == CNT_W'(STORE_DEPTH));
    assign is_append  = i_cmd.accept && (i_in_data.operation == gnps_pkg::OP_APPEND);
    assign is_query   = i_cmd.accept && (i_in_data.operation == gnps_pkg::OP_QUERY);
    assign is_clear   = i_cmd.accept && (i_in_data.operation == gnps_pkg::OP_CLEAR);

    assign o_status.count_zero = (r_count == '0);
    assign o_status.scan_last  = ({1'b0, r_scan_idx} == CNT_W'(r_count - 1'b1));
    assign o_status.pipe_busy  = r_s1_valid || r_s2_valid || r_s3_valid;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    // Store, count and gate.
    always_ff @(posedge i_clk) begin
        if (is_append && !count_full) begin
            mem[r_count[ADDR_W-1:0]] <= '{x: i_in_data.coord_x, y: i_in_data.coord_y,
                                          z: i_in_data.coord_z};
        end
        if (i_cmd.scan_read) begin
            r_s1_pt <= mem[r_scan_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_gate  <= gnps_pkg::GATE_RESET;
        end else begin
            if (i_cfg_wr) begin
                r_gate <= i_cfg_data;
            end
            if (is_clear) begin
                r_count <= '0;
            end else if (is_append && !count_full) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Accepted transaction context.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_query      <= '{x: i_in_data.coord_x, y: i_in_data.coord_y,
                              z: i_in_data.coord_z};
            r_pend_query <= is_query;
            r_pend_idx   <= r_count[ADDR_W-1:0];
            if (is_query) begin
                r_pend_status <= (r_count == '0) ? gnps_pkg::STATUS_EMPTY
                                                 : gnps_pkg::STATUS_OK;
            end else begin
                r_pend_status <= count_full ? gnps_pkg::STATUS_FULL
                                            : gnps_pkg::STATUS_OK;
            end
        end
    end

    // Distance pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx   <= '0;
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_s3_valid   <= 1'b0;
            r_best_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_scan_idx <= '0;
            end else if (i_cmd.scan_read) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            r_s1_valid <= i_cmd.scan_read;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            if (i_cmd.accept) begin
                r_best_valid <= 1'b0;
            end else if (r_s3_valid) begin
                r_best_valid <= 1'b1;
            end
        end
    end

    assign d_x = {r_s1_pt.x[CW-1], r_s1_pt.x} - {r_query.x[CW-1], r_query.x};
    assign d_y = {r_s1_pt.y[CW-1], r_s1_pt.y} - {r_query.y[CW-1], r_query.y};
    assign d_z = {r_s1_pt.z[CW-1], r_s1_pt.z} - {r_query.z[CW-1], r_query.z};
    assign p_x = d_x * d_x;
    assign p_y = d_y * d_y;
    assign p_z = d_z * d_z;

    // Distance pipeline payload.
    always_ff @(posedge i_clk) begin
        r_s1_idx  <= r_scan_idx;
        r_s2_idx  <= r_s1_idx;
        r_s2_pt   <= r_s1_pt;
        r_sq_x    <= DW'(unsigned'(p_x));
        r_sq_y    <= DW'(unsigned'(p_y));
        r_sq_z    <= DW'(unsigned'(p_z));
        r_s3_idx  <= r_s2_idx;
        r_s3_pt   <= r_s2_pt;
        r_s3_dist <= r_sq_x + r_sq_y + r_sq_z;
        // Strict less-than keeps the earliest point on a tie.
        if (r_s3_valid && (!r_best_valid || (r_s3_dist < r_best_dist))) begin
            r_best_idx  <= r_s3_idx;
            r_best_pt   <= r_s3_pt;
            r_best_dist <= r_s3_dist;
        end
    end

    // Result assembly.
    always_comb begin
        n_out        = '0;
        n_out.status = r_pend_status;
        if (r_pend_status == gnps_pkg::STATUS_OK) begin
            n_out.nearest_index = gnps_pkg::INDEX_W'(r_pend_query ? r_best_idx : r_pend_idx);
            if (r_pend_query) begin
                n_out.nearest_x   = r_best_pt.x;
                n_out.nearest_y   = r_best_pt.y;
                n_out.nearest_z   = r_best_pt.z;
                n_out.dist_sq     = r_best_dist;
                n_out.within_gate = (r_best_dist < r_gate);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_read |-> ({1'b0, r_scan_idx} < r_count))
        else $error("scan reads beyond the stored points");

    a_load_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_s1_valid || r_s2_valid || r_s3_valid))
        else $error("result loaded while distances are in flight");

    a_append_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_append && !count_full) |=> (r_count == CNT_W'($past(r_count) + 1'b1)))
        else $error("append did not advance the point count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STORE_DEPTH))
        else $error("point count exceeds store depth");

endmodule

/* src/gated_nearest_point_search.sv */
// ----------------------------------------------------------------------------
// gated_nearest_point_search: brute force nearest stored point in 3D
// Keeps a store of reference points and answers queries with the nearest
// one, its squared distance and a gate flag.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid, o_in_stall, i_in_data) carries one
// transaction per operation: append a point, query with a point, or clear.
// A transaction is taken at a rising edge with valid high and stall low.
// The output channel (o_out_valid, i_out_stall, o_out_data) returns one
// result per append or query; clear and the unused code return nothing.
// The gate register is written on its own channel (i_cfg_valid, o_cfg_ready,
// i_cfg_data), always ready; write it only while the block is idle.
// Sequence: an append or an empty query goes straight to the result
// hand-off, and the next transaction can be taken once the result is
// loaded. A query over N stored points holds off input while it scans
// them through the single read port of the point memory, one point per
// cycle, drains the distance pipeline and loads the output register. The
// load waits while a stalled result still holds the output register.
// Clear and the unused code keep the block idle. The block takes a new
// transaction as soon as it returns to idle, even while the previous result
// still waits in the output register.
// Reset clears the point count, the pipeline and the output valid, and
// loads the gate with 0.35 m squared. A stalled result holds unchanged.
// ----------------------------------------------------------------------------
module gated_nearest_point_search #(
    parameter int STORE_DEPTH = gnps_pkg::STORE_DEPTH_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  gnps_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output gnps_pkg::t_out_item         o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [gnps_pkg::DIST_W-1:0] i_cfg_data
);

    gnps_pkg::t_dp_cmd    cmd;
    gnps_pkg::t_dp_status status;

    // The gate register has no side effects, so writes are never held off.
    assign o_cfg_ready = 1'b1;

    // Controller: decides when to accept, scan, drain and hand off a result.
    gnps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_data.operation),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Datapath: point memory, distance pipeline, running minimum, output.
    gnps_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
